/* hw/rtl/fifo_queue_with_min_max_core_defines.svh */
// Assertion macros for the min/max queue core.
`ifndef FIFO_QUEUE_WITH_MIN_MAX_CORE_DEFINES_SVH
`define FIFO_QUEUE_WITH_MIN_MAX_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define FQMM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define FQMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FQMM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define FQMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/fqmm_pkg.sv */
`timescale 1ns / 1ps

package fqmm_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] out_value;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] smallest;
    logic signed [DATA_W-1:0] largest;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic first;
  } scan_ctl_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    next_idx = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

/* hw/rtl/fifo_queue_with_min_max_core.sv */
`timescale 1ns / 1ps
`include "fifo_queue_with_min_max_core_defines.svh"

// Sixteen-entry queue of signed 32-bit words that reports, after every
// enqueue or dequeue, the status, the dequeued word, the entry count and the
// smallest and largest stored words. Raise start with in_word while busy is
// low; the word is taken on that edge and busy stays high until the cycle in
// which the result is presented. The result appears on out_word for exactly
// one cycle with out_valid high and must be captured then, as it cannot be
// held off. A new command may be started in the same cycle as out_valid. The
// storage has one write and one read port; each command reads every entry
// left after the operation, one entry a cycle, into one shared min/max
// comparator pair, and a dequeue reads its word in the acceptance cycle.
module fifo_queue_with_min_max_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fqmm_pkg::in_word_t  in_word,
  output logic                out_valid,
  output fqmm_pkg::out_word_t out_word
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                             state_r, state_nxt;
  logic [fqmm_pkg::IDX_W-1:0]         head_r, head_nxt;
  logic [fqmm_pkg::IDX_W-1:0]         tail_r, tail_nxt;
  logic [fqmm_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [fqmm_pkg::IDX_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [fqmm_pkg::CNT_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic                               rv_r, rv_nxt;
  logic                               first_r, first_nxt;
  logic                               pop_r, pop_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [1:0]                         status_r, status_nxt;
  logic signed [fqmm_pkg::DATA_W-1:0] popped_r, popped_nxt;

  logic                               accept;
  logic                               issue;
  logic                               wr_en;
  logic [fqmm_pkg::IDX_W-1:0]         rd_addr;
  logic signed [fqmm_pkg::DATA_W-1:0] rd_data;
  logic signed [fqmm_pkg::DATA_W-1:0] lo;
  logic signed [fqmm_pkg::DATA_W-1:0] hi;
  fqmm_pkg::scan_ctl_t                scan_ctl;
  logic                               empty;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign issue  = (scan_idx_r != count_r);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    scan_idx_nxt  = scan_idx_r;
    rv_nxt        = 1'b0;
    first_nxt     = 1'b0;
    pop_nxt       = 1'b0;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    popped_nxt    = popped_r;
    wr_en         = 1'b0;
    rd_addr       = head_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt   = fqmm_pkg::ST_OK;
          popped_nxt   = '0;
          scan_idx_nxt = '0;
          state_nxt    = S_SCAN;
          rd_ptr_nxt   = head_r;
          if (in_word.op == fqmm_pkg::OP_ENQ) begin
            if (count_r == fqmm_pkg::CNT_W'(fqmm_pkg::DEPTH)) begin
              status_nxt = fqmm_pkg::ST_FULL;
            end else begin
              wr_en     = 1'b1;
              tail_nxt  = fqmm_pkg::next_idx(tail_r);
              count_nxt = count_r + 1'b1;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = fqmm_pkg::ST_EMPTY;
            end else begin
              pop_nxt    = 1'b1;
              head_nxt   = fqmm_pkg::next_idx(head_r);
              rd_ptr_nxt = fqmm_pkg::next_idx(head_r);
              count_nxt  = count_r - 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        rd_addr = rd_ptr_r;
        if (pop_r) begin
          popped_nxt = rd_data;
        end
        if (issue) begin
          rd_ptr_nxt   = fqmm_pkg::next_idx(rd_ptr_r);
          scan_idx_nxt = scan_idx_r + 1'b1;
          rv_nxt       = 1'b1;
          first_nxt    = (scan_idx_r == '0);
        end else if (!rv_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rd_ptr_r    <= '0;
      scan_idx_r  <= '0;
      rv_r        <= 1'b0;
      first_r     <= 1'b0;
      pop_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      scan_idx_r  <= scan_idx_nxt;
      rv_r        <= rv_nxt;
      first_r     <= first_nxt;
      pop_r       <= pop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    popped_r <= popped_nxt;
  end

  fqmm_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (in_word.value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign scan_ctl.valid = rv_r;
  assign scan_ctl.first = first_r;

  fqmm_scan u_scan (
    .clk  (clk),
    .ctl  (scan_ctl),
    .data (rd_data),
    .lo   (lo),
    .hi   (hi)
  );

  assign empty     = (count_r == '0);
  assign out_valid = out_valid_r;

  always_comb begin
    out_word.status      = status_r;
    out_word.out_value   = popped_r;
    out_word.entry_count = count_r;
    out_word.is_empty    = empty;
    out_word.smallest    = empty ? '0 : lo;
    out_word.largest     = empty ? '0 : hi;
  end

  `FQMM_ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1,
    count_r <= fqmm_pkg::CNT_W'(fqmm_pkg::DEPTH), "entry count above depth")
  `FQMM_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid_r, !out_valid_r,
    "result strobe longer than one cycle")
  `FQMM_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy && !out_valid_r,
    "accepted word did not start a scan")
  `FQMM_ASSERT_IMPLY(a_empty_ptrs, clk, rst_n, !busy && (count_r == '0),
    head_r == tail_r, "empty queue with head and tail apart")

endmodule

/* hw/rtl/fqmm_ram.sv */
`timescale 1ns / 1ps

module fqmm_ram (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [fqmm_pkg::IDX_W-1:0]         wr_addr,
  input  logic signed [fqmm_pkg::DATA_W-1:0] wr_data,
  input  logic [fqmm_pkg::IDX_W-1:0]         rd_addr,
  output logic signed [fqmm_pkg::DATA_W-1:0] rd_data
);

  logic signed [fqmm_pkg::DATA_W-1:0] mem_r [fqmm_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

/* hw/rtl/fqmm_scan.sv */
`timescale 1ns / 1ps

module fqmm_scan (
  input  logic                               clk,
  input  fqmm_pkg::scan_ctl_t                ctl,
  input  logic signed [fqmm_pkg::DATA_W-1:0] data,
  output logic signed [fqmm_pkg::DATA_W-1:0] lo,
  output logic signed [fqmm_pkg::DATA_W-1:0] hi
);

  logic signed [fqmm_pkg::DATA_W-1:0] lo_r, lo_nxt;
  logic signed [fqmm_pkg::DATA_W-1:0] hi_r, hi_nxt;

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (ctl.valid) begin
      if (ctl.first || (data < lo_r)) begin
        lo_nxt = data;
      end
      if (ctl.first || (data > hi_r)) begin
        hi_nxt = data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign lo = lo_r;
  assign hi = hi_r;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic                               op;
    logic signed [fqmm_pkg::DATA_W-1:0] value;
    logic                               typed;
    fqmm_pkg::out_word_t                report;
  } directed_row_t;

  localparam logic signed [fqmm_pkg::DATA_W-1:0] VAL_MIN =
    {1'b1, {(fqmm_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [fqmm_pkg::DATA_W-1:0] VAL_MAX =
    {1'b0, {(fqmm_pkg::DATA_W-1){1'b1}}};
  localparam int N_DIRECTED = 21;
  localparam int WORDS_PER_PHASE = 283;

  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{fqmm_pkg::OP_DEQ, 32'sh0000_1234, 1'b1,
      '{fqmm_pkg::ST_EMPTY, 32'sd0, 5'd0, 1'b1, 32'sd0, 32'sd0}},
    '{fqmm_pkg::OP_ENQ, -32'sd5, 1'b1,
      '{fqmm_pkg::ST_OK, 32'sd0, 5'd1, 1'b0, -32'sd5, -32'sd5}},
    '{fqmm_pkg::OP_ENQ, -32'sd7, 1'b1,
      '{fqmm_pkg::ST_OK, 32'sd0, 5'd2, 1'b0, -32'sd7, -32'sd5}},
    '{fqmm_pkg::OP_ENQ, VAL_MIN, 1'b1,
      '{fqmm_pkg::ST_OK, 32'sd0, 5'd3, 1'b0, VAL_MIN, -32'sd5}},
    '{fqmm_pkg::OP_ENQ, VAL_MAX, 1'b1,
      '{fqmm_pkg::ST_OK, 32'sd0, 5'd4, 1'b0, VAL_MIN, VAL_MAX}},
    '{fqmm_pkg::OP_ENQ, 32'sd0, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, -32'sd1, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, 32'sd1, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, 32'sh5555_5555, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, 32'shAAAA_AAAA, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, 32'sd100, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, -32'sd100, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, 32'sd7, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, 32'sd7, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, 32'sd42, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, -32'sd42, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, 32'sh0001_0000, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, 32'sd9, 1'b1,
      '{fqmm_pkg::ST_FULL, 32'sd0, 5'd16, 1'b0, VAL_MIN, VAL_MAX}},
    '{fqmm_pkg::OP_DEQ, 32'shFFFF_FFFF, 1'b0, '0},
    '{fqmm_pkg::OP_DEQ, 32'sd0, 1'b0, '0},
    '{fqmm_pkg::OP_ENQ, 32'sd3, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  fqmm_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  fqmm_pkg::out_word_t out_word;

  logic signed [fqmm_pkg::DATA_W-1:0] ring [fqmm_pkg::DEPTH];
  logic [fqmm_pkg::IDX_W-1:0]         oldest_slot = '0;
  logic [fqmm_pkg::IDX_W-1:0]         free_slot = '0;
  int unsigned                        held = 0;

  fqmm_pkg::out_word_t awaited_reports [$];
  int                  errors = 0;

  fifo_queue_with_min_max_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic fqmm_pkg::out_word_t compute_queue_report(input fqmm_pkg::in_word_t w);
    fqmm_pkg::out_word_t        r;
    logic [fqmm_pkg::IDX_W-1:0] s;
    r = '0;
    r.status = fqmm_pkg::ST_OK;
    if (w.op == fqmm_pkg::OP_ENQ) begin
      if (held == fqmm_pkg::DEPTH) begin
        r.status = fqmm_pkg::ST_FULL;
      end else begin
        ring[free_slot] = w.value;
        free_slot = (free_slot == fqmm_pkg::IDX_W'(fqmm_pkg::DEPTH - 1)) ? '0 :
                    free_slot + 1'b1;
        held++;
      end
    end else if (held == 0) begin
      r.status = fqmm_pkg::ST_EMPTY;
    end else begin
      r.out_value = ring[oldest_slot];
      oldest_slot = (oldest_slot == fqmm_pkg::IDX_W'(fqmm_pkg::DEPTH - 1)) ? '0 :
                    oldest_slot + 1'b1;
      held--;
    end
    r.entry_count = fqmm_pkg::CNT_W'(held);
    r.is_empty = (held == 0);
    if (held > 0) begin
      s = oldest_slot;
      r.smallest = ring[s];
      r.largest = ring[s];
      for (int k = 1; k < held; k++) begin
        s = (s == fqmm_pkg::IDX_W'(fqmm_pkg::DEPTH - 1)) ? '0 : s + 1'b1;
        if ($signed(ring[s]) < $signed(r.smallest)) r.smallest = ring[s];
        if ($signed(ring[s]) > $signed(r.largest)) r.largest = ring[s];
      end
    end
    return r;
  endfunction

  // hold start across back-to-back words; drop it only for an idle gap
  task automatic send_word(input fqmm_pkg::in_word_t w, input logic typed,
                           input fqmm_pkg::out_word_t report, input int idle_pct);
    int                  gap;
    fqmm_pkg::out_word_t predicted;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = compute_queue_report(w);
    awaited_reports.push_back(typed ? report : predicted);
  endtask

  task automatic flag_field(input string field, input logic signed [63:0] e,
                            input logic signed [63:0] g);
    $display("%0t %s expected %0d got %0d", $time, field, e, g);
    errors++;
  endtask

  always @(posedge clk) begin
    fqmm_pkg::out_word_t e;
    if (rst_n && out_valid) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t unexpected word expected none got %h", $time, out_word);
        errors++;
      end else begin
        e = awaited_reports.pop_front();
        if (out_word.status !== e.status) flag_field("status", e.status, out_word.status);
        if (out_word.out_value !== e.out_value)
          flag_field("out_value", e.out_value, out_word.out_value);
        if (out_word.entry_count !== e.entry_count)
          flag_field("entry_count", e.entry_count, out_word.entry_count);
        if (out_word.is_empty !== e.is_empty)
          flag_field("is_empty", e.is_empty, out_word.is_empty);
        if (out_word.smallest !== e.smallest)
          flag_field("smallest", e.smallest, out_word.smallest);
        if (out_word.largest !== e.largest)
          flag_field("largest", e.largest, out_word.largest);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    fqmm_pkg::in_word_t w;
    int                 enq_bias;
    int                 idle_pcts [3];
    idle_pcts = '{0, 54, 32};
    enq_bias = 50;
    for (int i = 0; i < fqmm_pkg::DEPTH; i++) ring[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      w.op = DIRECTED[i].op;
      w.value = DIRECTED[i].value;
      send_word(w, DIRECTED[i].typed, DIRECTED[i].report, 0);
    end

    // bias drifts so the queue keeps swinging between full and empty
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: enq_bias = 85;
            1: enq_bias = 50;
            default: enq_bias = 15;
          endcase
        end
        w.op = ($urandom_range(99) < enq_bias) ? fqmm_pkg::OP_ENQ : fqmm_pkg::OP_DEQ;
        case ($urandom_range(9))
          0: w.value = VAL_MIN;
          1: w.value = VAL_MAX;
          2: w.value = '0;
          3: w.value = -32'sd1;
          4, 5: w.value = $signed($urandom_range(40)) - 32'sd20;
          default: w.value = $urandom;
        endcase
        send_word(w, 1'b0, '0, idle_pcts[phase]);
      end
    end
    start <= 1'b0;

    for (int c = 0; c < 400 && awaited_reports.size() > 0; c++) @(posedge clk);
    repeat (25) @(posedge clk);
    if (awaited_reports.size() != 0) begin
      $display("%0t missing words expected 0 got %0d outstanding", $time,
               awaited_reports.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
